### sv/mhc_pkg.sv
// Shared types, constants and the arctangent table for the magnetometer heading block.
// Used by mhc_cal, mhc_cordic_cell and the top level; depends on nothing else.
package mhc_pkg;

  localparam int unsigned AngleIterDef = 16;
  localparam int unsigned TabLen       = 24;

  localparam int unsigned SmpW = 16;                  // raw sample and offset width
  localparam int unsigned DifW = 17;                  // offset-corrected sample width
  localparam int unsigned XyW  = 36;                  // rotator x/y width (value << 16 plus gain)
  localparam int unsigned ZW   = 25;                  // angle in 1/256 centidegree

  typedef enum logic [1:0] {
    ACT_MEASURE = 2'd0,
    ACT_SAMPLE  = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_START   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_UNDEF = 2'd1,
    ST_CAL   = 2'd2
  } status_e;

  localparam logic [1:0] RegOffsetX = 2'd0;
  localparam logic [1:0] RegOffsetY = 2'd1;
  localparam logic [1:0] RegOffsetZ = 2'd2;

  localparam logic signed [ZW-1:0] HalfTurn  = 25'sd4608000;
  localparam logic signed [ZW-1:0] Turn      = 25'sd9216000;
  localparam logic signed [ZW-1:0] RoundHalf = 25'sd128;

  localparam logic [15:0] Head0      = 16'd0;
  localparam logic [15:0] Head90     = 16'd9000;
  localparam logic [15:0] Head180    = 16'd18000;
  localparam logic [15:0] Head270    = 16'd27000;
  localparam logic [15:0] CentiTurn  = 16'd36000;

  typedef struct packed {
    logic signed [SmpW-1:0] x;
    logic signed [SmpW-1:0] y;
    logic signed [SmpW-1:0] z;
  } offsets_t;

  typedef struct packed {
    logic                  vld;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cord_t;

  // atan(2^-idx) in 1/256 centidegree, rounded
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 25'sd1152000;
      1:       a = 25'sd680065;
      2:       a = 25'sd359328;
      3:       a = 25'sd182400;
      4:       a = 25'sd91554;
      5:       a = 25'sd45822;
      6:       a = 25'sd22916;
      7:       a = 25'sd11459;
      8:       a = 25'sd5730;
      9:       a = 25'sd2865;
      10:      a = 25'sd1432;
      11:      a = 25'sd716;
      12:      a = 25'sd358;
      13:      a = 25'sd179;
      14:      a = 25'sd90;
      15:      a = 25'sd45;
      16:      a = 25'sd22;
      17:      a = 25'sd11;
      18:      a = 25'sd6;
      19:      a = 25'sd3;
      20:      a = 25'sd1;
      21:      a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### sv/magnetometer_heading_with_hard_iron_cal.sv
// Magnetometer compass heading with hard-iron calibration: top level.
// Depends on mhc_pkg, mhc_cal and mhc_cordic_cell.
//
// One item is worked at a time. An accepted item passes a front register, a chain of
// ANGLE_ITERATIONS rotation cells, a rounding stage and the output register. The slave
// side is ready again as soon as the result sits in the output register, so a new item
// is taken only once the last one is through; the length of the cell chain sets how
// often items are taken while the master side keeps up, and a stalled master side holds
// the next result in the rounding stage.
// Calibration actions also run through the chain and return heading 0 with the
// calibration status. Offsets written on the configuration port apply until the first
// finish-calibration item after reset.
module magnetometer_heading_with_hard_iron_cal #(
  parameter int unsigned ANGLE_ITERATIONS = mhc_pkg::AngleIterDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // sample items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // x_raw [15:0], y_raw [31:16], z_raw [47:32]
  input  logic [1:0]  s_axis_tuser,   // action [1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // heading_centideg, used_offset_x, _y, _z (16 b each)
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int unsigned N = ANGLE_ITERATIONS;

  logic                            in_take;
  logic                            busy_q;
  mhc_pkg::action_e                act_in;
  logic signed [mhc_pkg::SmpW-1:0] x_raw, y_raw, z_raw;
  mhc_pkg::offsets_t               offs;
  logic signed [mhc_pkg::DifW-1:0] dx_d, dy_d;

  // front register
  logic                            go_q;
  mhc_pkg::action_e                act_q;
  logic signed [mhc_pkg::DifW-1:0] dx_q, dy_q;
  mhc_pkg::offsets_t               offs_q;

  mhc_pkg::cord_t                  chain [N+1];
  logic                            neg;
  logic signed [mhc_pkg::DifW:0]   nx, ny;

  // rounding and result holding
  logic signed [mhc_pkg::ZW-1:0]   t1, rs;
  logic [15:0]                     r, head_rot;
  logic [15:0]                     head_d;
  mhc_pkg::status_e                st_d;
  logic                            hold_vld_q;
  logic [15:0]                     hold_head_q;
  mhc_pkg::status_e                hold_st_q;
  logic                            move;

  logic                            m_vld_q;
  logic [63:0]                     m_data_q;
  mhc_pkg::status_e                m_st_q;

  logic [N+1:0]                    tok;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign act_in        = mhc_pkg::action_e'(s_axis_tuser);
  assign x_raw         = s_axis_tdata[15:0];
  assign y_raw         = s_axis_tdata[31:16];
  assign z_raw         = s_axis_tdata[47:32];

  mhc_cal u_cal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (in_take),
    .action_i    (act_in),
    .x_i         (x_raw),
    .y_i         (y_raw),
    .z_i         (z_raw),
    .offs_o      (offs)
  );

  assign dx_d = $signed({x_raw[mhc_pkg::SmpW-1], x_raw})
              - $signed({offs.x[mhc_pkg::SmpW-1], offs.x});
  assign dy_d = $signed({y_raw[mhc_pkg::SmpW-1], y_raw})
              - $signed({offs.y[mhc_pkg::SmpW-1], offs.y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      go_q   <= 1'b0;
    end else begin
      go_q <= in_take;
      if (in_take) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q  <= act_in;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      offs_q <= offs;
    end
  end

  // left half-plane: negate the vector and start from half a turn
  assign neg = dx_q[mhc_pkg::DifW-1];
  assign nx  = neg ? -$signed({dx_q[mhc_pkg::DifW-1], dx_q})
                   : $signed({dx_q[mhc_pkg::DifW-1], dx_q});
  assign ny  = neg ? -$signed({dy_q[mhc_pkg::DifW-1], dy_q})
                   : $signed({dy_q[mhc_pkg::DifW-1], dy_q});

  always_comb begin
    chain[0].vld = go_q;
    chain[0].x   = {{(mhc_pkg::XyW-mhc_pkg::DifW-1-16){nx[mhc_pkg::DifW]}}, nx, 16'b0};
    chain[0].y   = {{(mhc_pkg::XyW-mhc_pkg::DifW-1-16){ny[mhc_pkg::DifW]}}, ny, 16'b0};
    chain[0].z   = neg ? mhc_pkg::HalfTurn : '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    mhc_cordic_cell #(.SHIFT(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (chain[g]),
      .out_o  (chain[g+1])
    );
  end

  // wrap into one turn, round half up to centidegrees
  assign t1       = chain[N].z[mhc_pkg::ZW-1] ? chain[N].z + mhc_pkg::Turn : chain[N].z;
  assign rs       = t1 + mhc_pkg::RoundHalf;
  assign r        = rs[mhc_pkg::ZW-2:8];
  assign head_rot = (r >= mhc_pkg::CentiTurn) ? r - mhc_pkg::CentiTurn : r;

  always_comb begin
    head_d = mhc_pkg::Head0;
    st_d   = mhc_pkg::ST_CAL;
    case (act_q)
      mhc_pkg::ACT_MEASURE: begin
        st_d = mhc_pkg::ST_VALID;
        if (dx_q == '0 && dy_q == '0) begin
          st_d = mhc_pkg::ST_UNDEF;
        end else if (dy_q == '0) begin
          head_d = dx_q[mhc_pkg::DifW-1] ? mhc_pkg::Head180 : mhc_pkg::Head0;
        end else if (dx_q == '0) begin
          head_d = dy_q[mhc_pkg::DifW-1] ? mhc_pkg::Head270 : mhc_pkg::Head90;
        end else begin
          head_d = head_rot;
        end
      end
      default: ;
    endcase
  end

  assign move = hold_vld_q && (!m_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      if (chain[N].vld) begin
        hold_vld_q <= 1'b1;
      end else if (move) begin
        hold_vld_q <= 1'b0;
      end
      if (move) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[N].vld) begin
      hold_head_q <= head_d;
      hold_st_q   <= st_d;
    end
    if (move) begin
      m_data_q <= {offs_q.z, offs_q.y, offs_q.x, hold_head_q};
      m_st_q   <= hold_st_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_st_q;

  always_comb begin
    tok[0] = go_q;
    for (int k = 1; k <= N; k++) begin
      tok[k] = chain[k].vld;
    end
    tok[N+1] = hold_vld_q;
  end

  // at most one item in flight between the front register and the holding stage
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok))
    else $error("more than one item in flight");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> busy_q)
    else $error("accepted item did not mark the block busy");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (tok == '0))
    else $error("item in flight while the block reports idle");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] < mhc_pkg::CentiTurn))
    else $error("heading out of range");

  a_move_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> m_axis_tvalid)
    else $error("held result did not reach the output register");

endmodule

### sv/mhc_cal.sv
// Hard-iron calibration: configured offsets, running per-axis extremes and midpoints.
// Depends on mhc_pkg.
module mhc_cal (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [mhc_pkg::SmpW-1:0]        cfg_data_i,
  input  logic                            take_i,
  input  mhc_pkg::action_e                action_i,
  input  logic signed [mhc_pkg::SmpW-1:0] x_i,
  input  logic signed [mhc_pkg::SmpW-1:0] y_i,
  input  logic signed [mhc_pkg::SmpW-1:0] z_i,
  output mhc_pkg::offsets_t               offs_o
);

  logic signed [mhc_pkg::SmpW-1:0] cfg_q [3];
  logic signed [mhc_pkg::SmpW-1:0] max_q [3];
  logic signed [mhc_pkg::SmpW-1:0] min_q [3];
  logic signed [mhc_pkg::SmpW-1:0] cal_q [3];
  logic                            calibrated_q;

  logic signed [mhc_pkg::SmpW-1:0] smp [3];
  logic signed [mhc_pkg::SmpW-1:0] mid [3];
  logic signed [mhc_pkg::SmpW-1:0] eff [3];
  logic signed [mhc_pkg::DifW-1:0] sum [3];
  logic signed [mhc_pkg::DifW-1:0] sum_adj [3];
  logic                            fin;

  assign smp[0] = x_i;
  assign smp[1] = y_i;
  assign smp[2] = z_i;
  assign fin    = (action_i == mhc_pkg::ACT_FINISH);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]     = $signed({min_q[a][mhc_pkg::SmpW-1], min_q[a]})
                 + $signed({max_q[a][mhc_pkg::SmpW-1], max_q[a]});
      // truncate toward zero: bias negative sums by one before the shift
      sum_adj[a] = sum[a] + $signed({{(mhc_pkg::DifW-1){1'b0}}, sum[a][mhc_pkg::DifW-1]});
      mid[a]     = sum_adj[a][mhc_pkg::DifW-1:1];
      if (fin) begin
        eff[a] = mid[a];
      end else if (calibrated_q) begin
        eff[a] = cal_q[a];
      end else begin
        eff[a] = cfg_q[a];
      end
    end
  end

  assign offs_o = '{x: eff[0], y: eff[1], z: eff[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cfg_q[a] <= '0;
        max_q[a] <= '0;
        min_q[a] <= '0;
        cal_q[a] <= '0;
      end
      calibrated_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mhc_pkg::RegOffsetX: cfg_q[0] <= cfg_data_i;
          mhc_pkg::RegOffsetY: cfg_q[1] <= cfg_data_i;
          mhc_pkg::RegOffsetZ: cfg_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (take_i) begin
        case (action_i)
          mhc_pkg::ACT_START: begin
            for (int a = 0; a < 3; a++) begin
              max_q[a] <= '0;
              min_q[a] <= '0;
            end
          end
          mhc_pkg::ACT_SAMPLE: begin
            for (int a = 0; a < 3; a++) begin
              if (smp[a] > max_q[a]) max_q[a] <= smp[a];
              if (smp[a] < min_q[a]) min_q[a] <= smp[a];
            end
          end
          mhc_pkg::ACT_FINISH: begin
            for (int a = 0; a < 3; a++) begin
              cal_q[a] <= mid[a];
            end
            calibrated_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/mhc_cordic_cell.sv
// One vectoring rotation step of the heading chain, with a fixed shift per cell.
// Depends on mhc_pkg (cord_t, angle table).
module mhc_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mhc_pkg::cord_t in_i,
  output mhc_pkg::cord_t out_o
);

  localparam logic signed [mhc_pkg::ZW-1:0] Angle = mhc_pkg::atan_entry(SHIFT);

  logic signed [mhc_pkg::XyW-1:0] x_in, y_in, x_sh, y_sh;
  logic signed [mhc_pkg::XyW-1:0] x_d, y_d, x_q, y_q;
  logic signed [mhc_pkg::ZW-1:0]  z_in, z_d, z_q;
  logic                           vld_q;

  assign x_in = in_i.x;
  assign y_in = in_i.y;
  assign z_in = in_i.z;
  assign x_sh = x_in >>> SHIFT;
  assign y_sh = y_in >>> SHIFT;

  always_comb begin
    // rotate toward the x axis
    if (!y_in[mhc_pkg::XyW-1]) begin
      x_d = x_in + y_sh;
      y_d = y_in - x_sh;
      z_d = z_in + Angle;
    end else begin
      x_d = x_in - y_sh;
      y_d = y_in + x_sh;
      z_d = z_in - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign out_o = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule

### dv/magnetometer_heading_with_hard_iron_cal_tb.sv
// Self-checking testbench for the magnetometer heading block with hard-iron calibration.
// Compares every result item with a CORDIC heading predictor kept in a scoreboard class.
// Depends on mhc_pkg and magnetometer_heading_with_hard_iron_cal.
module magnetometer_heading_with_hard_iron_cal_tb;

  localparam int unsigned Iters       = mhc_pkg::AngleIterDef;
  localparam int unsigned LimitCycles = 1_000_000;
  localparam int unsigned ItemTarget  = 1950;
  localparam logic [1:0]  RegUnused   = 2'd3;
  localparam longint      TurnUnits   = 9216000;
  localparam longint      HalfTurn    = 4608000;
  // atan(2^-i) in 1/256 centidegree
  localparam longint ArcTab [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  typedef struct packed {
    logic [15:0]      heading;
    mhc_pkg::status_e status;
    logic [15:0]      ox;
    logic [15:0]      oy;
    logic [15:0]      oz;
  } heading_res_t;

  class compass_scoreboard;
    mhc_pkg::offsets_t reg_off = '0;
    mhc_pkg::offsets_t mid_off = '0;
    int                hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
    bit                cal_done;
    heading_res_t      due_results[$];
    int                errors;
    int                n_checked;

    function mhc_pkg::offsets_t live_offsets();
      return cal_done ? mid_off : reg_off;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        mhc_pkg::RegOffsetX: reg_off.x = val;
        mhc_pkg::RegOffsetY: reg_off.y = val;
        mhc_pkg::RegOffsetZ: reg_off.z = val;
        default: ;
      endcase
    endfunction

    function int unsigned cordic_heading(int dx, int dy);
      longint x, y, ang, base, xs, ys, t;
      int i;
      if (dy == 0) return (dx > 0) ? 0 : 18000;
      if (dx == 0) return (dy > 0) ? 9000 : 27000;
      x = longint'(dx) * 65536;
      y = longint'(dy) * 65536;
      ang = 0;
      base = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
        x = -x;
        y = -y;
        base = HalfTurn;
      end
      for (i = 0; i < Iters && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          ang = ang + ArcTab[i];
        end else begin
          x = x - ys;
          y = y + xs;
          ang = ang - ArcTab[i];
        end
      end
      t = base + ang;
      if (t < 0) t = t + TurnUnits;
      t = (t + 128) >>> 8;
      if (t >= 36000) t = t - 36000;
      return int'(t);
    endfunction

    function void note_sample(logic [1:0] act, logic [15:0] xr, logic [15:0] yr,
                              logic [15:0] zr);
      int sx, sy, sz, dx, dy;
      mhc_pkg::offsets_t off;
      heading_res_t r;
      sx = signed'(xr);
      sy = signed'(yr);
      sz = signed'(zr);
      case (act)
        mhc_pkg::ACT_START: begin
          hi_x = 0; hi_y = 0; hi_z = 0;
          lo_x = 0; lo_y = 0; lo_z = 0;
        end
        mhc_pkg::ACT_SAMPLE: begin
          if (sx > hi_x) hi_x = sx;
          if (sy > hi_y) hi_y = sy;
          if (sz > hi_z) hi_z = sz;
          if (sx < lo_x) lo_x = sx;
          if (sy < lo_y) lo_y = sy;
          if (sz < lo_z) lo_z = sz;
        end
        mhc_pkg::ACT_FINISH: begin
          mid_off.x = 16'((lo_x + hi_x) / 2);
          mid_off.y = 16'((lo_y + hi_y) / 2);
          mid_off.z = 16'((lo_z + hi_z) / 2);
          cal_done = 1'b1;
        end
        default: ;
      endcase
      off = live_offsets();
      r.heading = '0;
      r.status = mhc_pkg::ST_CAL;
      if (act == mhc_pkg::ACT_MEASURE) begin
        dx = sx - int'(off.x);
        dy = sy - int'(off.y);
        if (dx == 0 && dy == 0) begin
          r.status = mhc_pkg::ST_UNDEF;
        end else begin
          r.heading = 16'(cordic_heading(dx, dy));
          r.status = mhc_pkg::ST_VALID;
        end
      end
      r.ox = off.x;
      r.oy = off.y;
      r.oz = off.z;
      due_results.push_back(r);
    endfunction

    function void check_heading(logic [63:0] data, logic [1:0] user);
      heading_res_t got, want;
      got.heading = data[15:0];
      got.ox = data[31:16];
      got.oy = data[47:32];
      got.oz = data[63:48];
      got.status = mhc_pkg::status_e'(user);
      n_checked++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with none outstanding: heading %0d status %0d",
                   n_checked, got.heading, got.status);
        return;
      end
      want = due_results.pop_front();
      if (got.heading !== want.heading || got.status !== want.status ||
          got.ox !== want.ox || got.oy !== want.oy || got.oz !== want.oz) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d mismatch: heading exp %0d act %0d, status exp %0d act %0d,",
                    " offsets exp %0d/%0d/%0d act %0d/%0d/%0d"},
                   n_checked, want.heading, got.heading, want.status, got.status,
                   $signed(want.ox), $signed(want.oy), $signed(want.oz),
                   $signed(got.ox), $signed(got.oy), $signed(got.oz));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // x_raw [15:0], y_raw [31:16], z_raw [47:32]
  logic [1:0]  s_axis_tuser = '0;   // action [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // heading, used_offset_x, _y, _z
  logic [1:0]  m_axis_tuser;        // status [1:0]

  compass_scoreboard sb;
  int unsigned cycle_count = 0;
  int          n_sent = 0;
  int          burst_left = 0;
  bit          tx_held = 1'b0;
  int          rx_mode = 0;
  int          rx_left = 0;

  magnetometer_heading_with_hard_iron_cal #(
    .ANGLE_ITERATIONS(Iters)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("magnetometer_heading_with_hard_iron_cal verification failed");
      $finish;
    end
  end

  // check results before noting a new item: a result never belongs to the item taken with it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_heading(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                       s_axis_tdata[47:32]);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // receiver: always ready, coin flip, or mostly stalled, switching mode in runs of random length
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      3: return 16'($urandom_range(0, 800)) - 16'd400;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_item(mhc_pkg::action_e act, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {z, y, x};
    tx_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        burst_left = $urandom_range(0, 15);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        tx_held = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // steer an axis onto the live offset now and then to reach the axis and origin cases
  task automatic send_measure();
    logic [15:0] x, y;
    mhc_pkg::offsets_t off;
    x = pick_axis();
    y = pick_axis();
    off = sb.live_offsets();
    case ($urandom_range(0, 11))
      0: x = off.x;
      1: y = off.y;
      2: begin
        x = off.x;
        y = off.y;
      end
      default: ;
    endcase
    send_item(mhc_pkg::ACT_MEASURE, x, y, pick_axis());
  endtask

  // drop valid and hold until the block has returned everything
  task automatic settle();
    if (tx_held) begin
      s_axis_tvalid <= 1'b0;
      tx_held = 1'b0;
    end
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (Iters + 4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic cfg_close();
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
    cfg_write(mhc_pkg::RegOffsetX, ox);
    cfg_write(mhc_pkg::RegOffsetY, oy);
    cfg_write(mhc_pkg::RegOffsetZ, oz);
    cfg_close();
  endtask

  initial begin
    int k;
    int p;
    bit wrote_late;
    logic [15:0] settings [4][3];
    sb = new;
    wrote_late = 1'b0;
    settings = '{'{16'($urandom()), 16'($urandom()), 16'($urandom())},
                 '{16'h7FFF, 16'h7FFF, 16'h7FFF},
                 '{16'h8000, 16'h8000, 16'h8000},
                 '{16'h0000, 16'h0000, 16'h0000}};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // axes, origin and the range ends with reset offsets
    send_item(mhc_pkg::ACT_MEASURE, 16'd0, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, 16'd100, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, -16'sd100, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, 16'd0, 16'd100, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, 16'd0, -16'sd100, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(mhc_pkg::ACT_MEASURE, 16'h8000, 16'h8000, 16'h8000);
    send_item(mhc_pkg::ACT_MEASURE, 16'h7FFF, 16'hFFFF, 16'h0000);   // rounds up to a full turn
    send_item(mhc_pkg::ACT_MEASURE, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(mhc_pkg::ACT_MEASURE, 16'h0001, 16'hFFFF, 16'h0000);
    settle();
    // widest corrected span: offsets at one end, samples at the other
    load_offsets(16'h7FFF, 16'h8000, 16'h1234);
    send_item(mhc_pkg::ACT_MEASURE, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(mhc_pkg::ACT_MEASURE, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_item(mhc_pkg::ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send_item(mhc_pkg::ACT_START, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    settle();
    cfg_write(RegUnused, 16'hABCD);
    cfg_close();
    send_item(mhc_pkg::ACT_MEASURE, 16'd0, 16'd0, 16'd0);

    // configured offsets only: no finish before the calibration phase
    for (p = 0; p < 4; p++) begin
      settle();
      load_offsets(settings[p][0], settings[p][1], settings[p][2]);
      for (k = 0; k < 120; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: send_item(mhc_pkg::ACT_SAMPLE, pick_axis(), pick_axis(), pick_axis());
          3, 4, 5: send_item(mhc_pkg::ACT_START, pick_axis(), pick_axis(), pick_axis());
          default: send_measure();
        endcase
      end
    end
    settle();

    // first calibration, midpoints truncated toward zero
    send_item(mhc_pkg::ACT_START, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(mhc_pkg::ACT_SAMPLE, 16'd100, -16'sd300, 16'd7);
    send_item(mhc_pkg::ACT_SAMPLE, -16'sd50, 16'd20, -16'sd8);
    send_item(mhc_pkg::ACT_FINISH, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(mhc_pkg::ACT_MEASURE, 16'd25, -16'sd140, 16'd0);
    // finish with no samples, then samples without a start
    send_item(mhc_pkg::ACT_START, 16'd0, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_FINISH, 16'd0, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_MEASURE, 16'd0, 16'd0, 16'd0);
    send_item(mhc_pkg::ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(mhc_pkg::ACT_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(mhc_pkg::ACT_FINISH, 16'd0, 16'd0, 16'd0);
    settle();
    // stored but without effect once calibrated
    load_offsets(16'h4000, 16'hC000, 16'h0101);
    send_item(mhc_pkg::ACT_MEASURE, 16'h0010, 16'h0000, 16'h0000);

    while (n_sent < ItemTarget) begin
      if (!wrote_late && n_sent > 1400) begin
        settle();
        load_offsets(16'($urandom()), 16'($urandom()), 16'($urandom()));
        wrote_late = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        send_item(mhc_pkg::action_e'($urandom_range(0, 3)), pick_axis(), pick_axis(),
                  pick_axis());
      end else begin
        send_item(mhc_pkg::ACT_START, pick_axis(), pick_axis(), pick_axis());
        repeat ($urandom_range(0, 12))
          send_item(mhc_pkg::ACT_SAMPLE, pick_axis(), pick_axis(), pick_axis());
        send_item(mhc_pkg::ACT_FINISH, pick_axis(), pick_axis(), pick_axis());
        repeat ($urandom_range(1, 10)) send_measure();
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("magnetometer_heading_with_hard_iron_cal verification clean");
    end else begin
      $display("magnetometer_heading_with_hard_iron_cal verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mhc_pkg.sv
sv/mhc_cal.sv
sv/mhc_cordic_cell.sv
sv/magnetometer_heading_with_hard_iron_cal.sv
dv/magnetometer_heading_with_hard_iron_cal_tb.sv
